@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the lock manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |=> (cons), msg)

`endif

@@ src/rorw_pkg.sv @@
// Shared constants and types of the ring-order reader-writer lock manager.
`timescale 1ns / 1ps

package rorw_pkg;

   localparam int SLOTS      = 8;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int REQ_SLOT_W = 3;
   localparam int KIND_W     = 2;
   localparam int DATA_W     = 8;

   localparam logic [KIND_W-1:0] REQ_READ    = KIND_W'(0);
   localparam logic [KIND_W-1:0] REQ_WRITE   = KIND_W'(1);
   localparam logic [KIND_W-1:0] REQ_RELEASE = KIND_W'(2);

   typedef enum logic [1:0] {
      FLAG_IDLE    = 2'd0,
      FLAG_APPLY   = 2'd1,
      FLAG_APPROVE = 2'd2
   } flag_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_RD_APPROVE,
      OP_RD_APPLY,
      OP_RD_IDLE,
      OP_WR_APPLY,
      OP_WR_APPROVE,
      OP_WALK_START
   } cell_op_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      cell_op_type       op;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] nxt;
      logic              advance;
   } cell_cmd_type;

   // Status of one cell back to the controller.
   typedef struct packed {
      flag_type rd_flag;
      logic     grant;
      logic     found;
      logic     done;
   } cell_stat_type;

endpackage

@@ src/rorw_cell.sv @@
// One ring slot: reader and writer flags plus the walk token stage.
`timescale 1ns / 1ps

module rorw_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rorw_pkg::SLOT_W-1:0]   cell_id,
   input  rorw_pkg::cell_cmd_type        cmd,
   input  logic                          token_prev,
   output logic                          token_next,
   output rorw_pkg::cell_stat_type       stat
);
   import rorw_pkg::*;

   flag_type rd_ff, rd_in;
   flag_type wr_ff, wr_in;
   logic     tok_ff, tok_in;
   logic     home_ff, home_in;
   logic     hit;
   logic     nxt_hit;
   logic     act;

   always_comb begin
      hit        = (cmd.slot == cell_id);
      nxt_hit    = (cmd.nxt == cell_id);
      act        = tok_ff && cmd.advance;
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      tok_in     = tok_ff;
      home_in    = home_ff;
      token_next = 1'b0;
      stat.rd_flag = rd_ff;
      stat.grant   = 1'b0;
      stat.found   = 1'b0;
      stat.done    = 1'b0;

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_RD_APPROVE: begin
            if (hit) rd_in = FLAG_APPROVE;
         end
         OP_RD_APPLY: begin
            if (hit) rd_in = FLAG_APPLY;
         end
         OP_RD_IDLE: begin
            if (hit) rd_in = FLAG_IDLE;
         end
         OP_WR_APPLY: begin
            if (hit) wr_in = FLAG_APPLY;
         end
         OP_WR_APPROVE: begin
            if (hit) wr_in = FLAG_APPROVE;
         end
         OP_WALK_START: begin
            home_in = hit;
            if (hit) wr_in = FLAG_IDLE;
            if (nxt_hit) tok_in = 1'b1;
         end
      endcase

      // Token held and advancing: back home ends the walk and grants a queued reader there,
      // an applying writer stops it, otherwise grant a queued reader and pass the token on.
      if (act) begin
         tok_in = 1'b0;
         if (home_ff) begin
            stat.done = 1'b1;
            home_in   = 1'b0;
            if (rd_ff == FLAG_APPLY) begin
               rd_in      = FLAG_APPROVE;
               stat.grant = 1'b1;
            end
         end else if (wr_ff == FLAG_APPLY) begin
            stat.found = 1'b1;
         end else begin
            token_next = 1'b1;
            if (rd_ff == FLAG_APPLY) begin
               rd_in      = FLAG_APPROVE;
               stat.grant = 1'b1;
            end
         end
      end

      if (token_prev) tok_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff   <= FLAG_IDLE;
         wr_ff   <= FLAG_IDLE;
         tok_ff  <= 1'b0;
         home_ff <= 1'b0;
      end else begin
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
         tok_ff  <= tok_in;
         home_ff <= home_in;
      end
   end

endmodule

@@ src/rorw_ctrl.sv @@
// Request sequencer, owner state and grant output staging.
`timescale 1ns / 1ps

module rorw_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rorw_pkg::KIND_W-1:0]          req_kind,
   input  logic [rorw_pkg::REQ_SLOT_W-1:0]      req_slot,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rorw_pkg::REQ_SLOT_W-1:0]      rsp_slot,
   output logic                                 rsp_writer,
   output logic                                 rsp_last,
   input  rorw_pkg::cell_stat_type              stat [rorw_pkg::SLOTS],
   output rorw_pkg::cell_cmd_type               cmd
);
   import rorw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TRY,
      S_WALK,
      S_FLUSH
   } state_type;

   state_type                state_ff, state_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [REQ_SLOT_W-1:0]    slot_ff, slot_in;
   logic                     ov_ff, ov_in;
   logic                     og_ff, og_in;
   logic [SLOT_W-1:0]        os_ff, os_in;
   logic                     pend_v_ff, pend_v_in;
   logic [SLOT_W-1:0]        pend_slot_ff, pend_slot_in;
   logic                     pend_wr_ff, pend_wr_in;
   logic                     out_v_ff, out_v_in;
   logic [REQ_SLOT_W-1:0]    out_slot_ff, out_slot_in;
   logic                     out_wr_ff, out_wr_in;
   logic                     out_last_ff, out_last_in;

   logic [SLOT_W-1:0]        s_idx;
   logic                     slot_ok;
   flag_type                 rd_s;
   logic                     clear;
   logic                     grant_any, found_any, done_any;
   logic [SLOT_W-1:0]        grant_idx, found_idx;
   logic                     out_free, can_push;
   logic                     emit, flush;
   logic [SLOT_W-1:0]        emit_slot;
   logic                     emit_wr;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_slot   = out_slot_ff;
   assign rsp_writer = out_wr_ff;
   assign rsp_last   = out_last_ff;

   always_comb begin
      s_idx   = SLOT_W'(slot_ff);
      slot_ok = (32'(slot_ff) < SLOTS);
      rd_s    = stat[s_idx].rd_flag;

      // Readers still approved outside the owner slot block the owner grant.
      clear     = 1'b1;
      grant_any = 1'b0;
      found_any = 1'b0;
      done_any  = 1'b0;
      grant_idx = '0;
      found_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (SLOT_W'(i) != os_ff && stat[i].rd_flag == FLAG_APPROVE) clear = 1'b0;
         if (stat[i].grant) begin
            grant_any = 1'b1;
            grant_idx = SLOT_W'(i);
         end
         if (stat[i].found) begin
            found_any = 1'b1;
            found_idx = SLOT_W'(i);
         end
         if (stat[i].done) done_any = 1'b1;
      end

      out_free = !out_v_ff || rsp_tready;
      can_push = !pend_v_ff || out_free;

      state_in    = state_ff;
      kind_in     = kind_ff;
      slot_in     = slot_ff;
      ov_in       = ov_ff;
      og_in       = og_ff;
      os_in       = os_ff;
      emit        = 1'b0;
      emit_slot   = s_idx;
      emit_wr     = 1'b0;
      flush       = 1'b0;
      cmd.op      = OP_NONE;
      cmd.slot    = s_idx;
      cmd.nxt     = (s_idx == SLOT_W'(SLOTS - 1)) ? '0 : s_idx + SLOT_W'(1);
      cmd.advance = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_kind;
               slot_in  = req_slot;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FLUSH;
            if (slot_ok) begin
               unique case (kind_ff)
                  REQ_READ: begin
                     if (rd_s != FLAG_APPROVE) begin
                        if (!ov_ff) begin
                           cmd.op = OP_RD_APPROVE;
                           emit   = 1'b1;
                        end else begin
                           cmd.op = OP_RD_APPLY;
                        end
                     end
                  end
                  REQ_WRITE: begin
                     if (!(ov_ff && os_ff == s_idx)) begin
                        cmd.op = OP_WR_APPLY;
                        if (!ov_ff) begin
                           ov_in    = 1'b1;
                           os_in    = s_idx;
                           og_in    = 1'b0;
                           state_in = S_TRY;
                        end
                     end
                  end
                  REQ_RELEASE: begin
                     if (rd_s == FLAG_APPROVE) begin
                        cmd.op   = OP_RD_IDLE;
                        state_in = S_TRY;
                     end else if (ov_ff && og_ff && os_ff == s_idx) begin
                        cmd.op   = OP_WALK_START;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TRY: begin
            cmd.slot = os_ff;
            if (ov_ff && !og_ff && clear) begin
               if (can_push) begin
                  cmd.op    = OP_WR_APPROVE;
                  og_in     = 1'b1;
                  emit      = 1'b1;
                  emit_slot = os_ff;
                  emit_wr   = 1'b1;
                  state_in  = S_FLUSH;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_WALK: begin
            cmd.advance = can_push;
            if (grant_any) begin
               emit      = 1'b1;
               emit_slot = grant_idx;
            end
            if (found_any) begin
               os_in    = found_idx;
               og_in    = 1'b0;
               state_in = S_TRY;
            end else if (done_any) begin
               ov_in    = 1'b0;
               og_in    = 1'b0;
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               flush    = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase

      // Grant staging: the newest grant waits in the pending stage until the
      // next one, or the end of the request, tells whether it is the last.
      pend_v_in    = pend_v_ff;
      pend_slot_in = pend_slot_ff;
      pend_wr_in   = pend_wr_ff;
      out_v_in     = out_v_ff && !rsp_tready;
      out_slot_in  = out_slot_ff;
      out_wr_in    = out_wr_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_slot_in = REQ_SLOT_W'(pend_slot_ff);
            out_wr_in   = pend_wr_ff;
            out_last_in = 1'b0;
         end
         pend_v_in    = 1'b1;
         pend_slot_in = emit_slot;
         pend_wr_in   = emit_wr;
      end
      if (flush) begin
         out_v_in    = 1'b1;
         out_slot_in = REQ_SLOT_W'(pend_slot_ff);
         out_wr_in   = pend_wr_ff;
         out_last_in = 1'b1;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      slot_ff      <= slot_in;
      pend_slot_ff <= pend_slot_in;
      pend_wr_ff   <= pend_wr_in;
      out_slot_ff  <= out_slot_in;
      out_wr_ff    <= out_wr_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         ov_ff     <= 1'b0;
         og_ff     <= 1'b0;
         os_ff     <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ov_ff     <= ov_in;
         og_ff     <= og_in;
         os_ff     <= os_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

endmodule

@@ src/ring_order_reader_writer_lock_core.sv @@
// Top level of the ring-order reader-writer lock manager.
`timescale 1ns / 1ps
// Timing: a read grant passes the pending stage into the output register; a
//    writer grant goes through the try state first; a writer release walks a
//    token one ring cell per cycle while the grant stages can take a grant.
// Requests: one at a time; a new request is taken only after the last one
//    has handed its final grant to the output register.
// Reset: synchronous, active high; all flags idle, no owner, no grant pending.

module ring_order_reader_writer_lock_core (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [2:0] requester, [7:3] zero
   input  logic [1:0] req_tuser,   // [1:0] req_type
   // grant channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] grant_slot, [7:3] zero
   output logic [0:0] rsp_tuser,   // [0] grant_writer
   output logic       rsp_tlast    // last_grant
);
   import rorw_pkg::*;

   cell_cmd_type          cmd;
   cell_stat_type         stat [SLOTS];
   logic                  tok_chain [SLOTS];
   logic [REQ_SLOT_W-1:0] rsp_slot;
   logic                  rsp_writer;

   // Sequence requests, hold owner state and stage grants toward the output.
   rorw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_slot   (req_tdata[REQ_SLOT_W-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_slot   (rsp_slot),
      .rsp_writer (rsp_writer),
      .rsp_last   (rsp_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Ring of slot cells; the walk token passes from each cell to the next one,
   // with the last cell handing back to the first.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      localparam int PREV = (i == 0) ? SLOTS - 1 : i - 1;
      rorw_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_id    (SLOT_W'(i)),
         .cmd        (cmd),
         .token_prev (tok_chain[PREV]),
         .token_next (tok_chain[i]),
         .stat       (stat[i])
      );
   end

   // Pack grant fields; pad bits stay zero.
   assign rsp_tdata = {{(DATA_W - REQ_SLOT_W){1'b0}}, rsp_slot};
   assign rsp_tuser = rsp_writer;

endmodule

@@ src/rorw_checker.sv @@
// Port-level checks of the lock manager, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rorw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser,
   input logic       rsp_tlast
);

   logic       rsp_stall;
   logic       req_take;
   logic       wr_grant;
   logic [9:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_take  = req_tvalid && req_tready;
   assign wr_grant  = rsp_tvalid && rsp_tuser[0];
   assign rsp_word  = {rsp_tlast, rsp_tuser, rsp_tdata};

   // A stalled grant stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid, "stalled grant dropped")

   // A stalled grant keeps its payload.
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_word), "stalled grant changed")

   // Requests are served one at a time.
   `ASSERT_NEXT(a_one_req, clock, reset, req_take, !req_tready, "request taken while busy")

   // A writer grant ends the grants of its request.
   `ASSERT_SAME(a_writer_last, clock, reset, wr_grant, rsp_tlast, "writer grant not last")

endmodule

bind ring_order_reader_writer_lock_core rorw_checker u_rorw_checker (.*);

@@ sim/ring_order_reader_writer_lock_core_tb.sv @@
// Self-checking bench for the ring-order reader-writer lock manager, with random stalls.
`timescale 1ns / 1ps

module ring_order_reader_writer_lock_core_tb;
   import rorw_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int RESET_LEN   = 9;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 24;
   localparam int REPORT_MAX  = 10;

   // Request code that the block must drop without a grant.
   localparam logic [KIND_W-1:0] REQ_UNKNOWN = KIND_W'(3);

   typedef struct {
      logic [KIND_W-1:0]     kind;
      logic [REQ_SLOT_W-1:0] slot;
   } lock_req_type;

   typedef struct {
      logic [REQ_SLOT_W-1:0] slot;
      logic                  writer;
      logic                  last;
   } grant_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;  // [2:0] requester, [7:3] zero
   logic [1:0] req_tuser  = '0;  // [1:0] req_type
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [2:0] grant_slot, [7:3] zero
   logic [0:0] rsp_tuser;        // [0] grant_writer
   logic       rsp_tlast;

   ring_order_reader_writer_lock_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLK_HALF clock = ~clock;

   // Stimulus waiting to be driven, grants still owed by the block.
   lock_req_type pending_reqs[$];
   grant_type    grants_due[$];
   grant_type    step_grants[$];

   // Shadow of the lock state: per-slot reader and writer flags plus the owner.
   flag_type              rd_flag[SLOTS];
   flag_type              wr_flag[SLOTS];
   logic [REQ_SLOT_W-1:0] own_slot    = '0;
   logic                  own_valid   = 1'b0;
   logic                  own_granted = 1'b0;

   // Slots that the random generator has sent a lock request from.
   bit asked[SLOTS];

   bit calm       = 1'b0;  // suppress idling on both sides
   int mismatches = 0;
   int cycle_count = 0;

   initial begin
      foreach (rd_flag[i]) begin
         rd_flag[i] = FLAG_IDLE;
         wr_flag[i] = FLAG_IDLE;
      end
   end

   function automatic void add_grant(input int slot, input logic writer);
      grant_type g;
      g.slot   = REQ_SLOT_W'(slot);
      g.writer = writer;
      g.last   = 1'b0;
      step_grants.push_back(g);
   endfunction

   // The waiting owner goes ahead once no reader outside its own slot is approved.
   function automatic void grant_waiting_owner();
      bit readers_out;
      readers_out = 1'b1;
      if (!own_valid || own_granted || own_slot >= SLOTS) return;
      for (int i = 0; i < SLOTS; i++) begin
         if (i != own_slot && rd_flag[i] == FLAG_APPROVE) readers_out = 1'b0;
      end
      if (readers_out) begin
         wr_flag[own_slot] = FLAG_APPROVE;
         own_granted       = 1'b1;
         add_grant(own_slot, 1'b1);
      end
   endfunction

   // Walk the ring after the releasing writer: wake queued readers up to the
   // next applying writer, or free the lock if none applies.
   function automatic void hand_off_writer(input int slot);
      int nx;
      wr_flag[slot] = FLAG_IDLE;
      for (int i = 1; i < SLOTS; i++) begin
         nx = (slot + i) % SLOTS;
         if (wr_flag[nx] == FLAG_APPLY) begin
            own_slot    = REQ_SLOT_W'(nx);
            own_granted = 1'b0;
            grant_waiting_owner();
            return;
         end
         if (rd_flag[nx] == FLAG_APPLY) begin
            rd_flag[nx] = FLAG_APPROVE;
            add_grant(nx, 1'b0);
         end
      end
      own_valid   = 1'b0;
      own_granted = 1'b0;
      // A reader queued in the releasing slot itself comes last.
      if (rd_flag[slot] == FLAG_APPLY) begin
         rd_flag[slot] = FLAG_APPROVE;
         add_grant(slot, 1'b0);
      end
   endfunction

   // Apply one accepted request to the shadow state and queue its grants.
   function automatic void predict_grants(input logic [KIND_W-1:0] kind,
                                          input logic [REQ_SLOT_W-1:0] slot);
      step_grants.delete();
      if (slot >= SLOTS) return;
      case (kind)
         REQ_READ: begin
            if (rd_flag[slot] != FLAG_APPROVE) begin
               if (!own_valid) begin
                  rd_flag[slot] = FLAG_APPROVE;
                  add_grant(slot, 1'b0);
               end else begin
                  rd_flag[slot] = FLAG_APPLY;
               end
            end
         end
         REQ_WRITE: begin
            if (!(own_valid && own_slot == slot)) begin
               wr_flag[slot] = FLAG_APPLY;
               if (!own_valid) begin
                  own_valid   = 1'b1;
                  own_slot    = slot;
                  own_granted = 1'b0;
                  grant_waiting_owner();
               end
            end
         end
         REQ_RELEASE: begin
            // An approved reader in the slot goes before its writer ownership.
            if (rd_flag[slot] == FLAG_APPROVE) begin
               rd_flag[slot] = FLAG_IDLE;
               grant_waiting_owner();
            end else if (own_valid && own_granted && own_slot == slot) begin
               hand_off_writer(slot);
            end
         end
         default: ;
      endcase
      if (step_grants.size() > 0) step_grants[step_grants.size() - 1].last = 1'b1;
      foreach (step_grants[i]) grants_due.push_back(step_grants[i]);
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%s", msg);
   endfunction

   // Request driver: hold a presented transfer until taken, then advance.
   always @(posedge clock) begin : drive_requests
      lock_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_grants(req_tuser, req_tdata[REQ_SLOT_W-1:0]);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(8 - REQ_SLOT_W){1'b0}}, nxt.slot};
               req_tuser  <= nxt.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Grant monitor: compare every transfer with the oldest grant owed.
   always @(posedge clock) begin : check_grants
      grant_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (grants_due.size() == 0) begin
               note_mismatch($sformatf("unexpected grant: slot %0d writer %0d last %0d",
                                       rsp_tdata, rsp_tuser[0], rsp_tlast));
            end else begin
               want = grants_due.pop_front();
               if (rsp_tdata !== {{(8 - REQ_SLOT_W){1'b0}}, want.slot} ||
                   rsp_tuser[0] !== want.writer || rsp_tlast !== want.last) begin
                  note_mismatch($sformatf(
                     "grant mismatch: expected slot %0d writer %0d last %0d, got %0d %0d %0d",
                     want.slot, want.writer, want.last, rsp_tdata, rsp_tuser[0], rsp_tlast));
               end
            end
         end
         rsp_tready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ring_order_reader_writer_lock_core_tb: FAIL");
         $finish;
      end
   end

   task automatic queue_request(input logic [KIND_W-1:0] kind, input int slot);
      lock_req_type r;
      r.kind = kind;
      r.slot = REQ_SLOT_W'(slot);
      pending_reqs.push_back(r);
   endtask

   // Mostly lock requests and releases from slots that asked for the lock,
   // with stray releases and unknown codes mixed in.
   task automatic queue_random_requests(input int count);
      int roll;
      int pick;
      int busy[$];
      repeat (count) begin
         roll = $urandom_range(99);
         pick = $urandom_range(SLOTS - 1);
         busy.delete();
         foreach (asked[i]) begin
            if (asked[i]) busy.push_back(i);
         end
         if (roll < 35) begin
            queue_request(REQ_READ, pick);
            asked[pick] = 1'b1;
         end else if (roll < 60) begin
            queue_request(REQ_WRITE, pick);
            asked[pick] = 1'b1;
         end else if (roll < 95) begin
            if (busy.size() > 0 && $urandom_range(99) < 85)
               pick = busy[$urandom_range(busy.size() - 1)];
            queue_request(REQ_RELEASE, pick);
            asked[pick] = 1'b0;
         end else begin
            queue_request(REQ_UNKNOWN, pick);
         end
      end
   endtask

   // Hold until every request is taken and every owed grant has arrived.
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || grants_due.size() != 0);
   endtask

   initial begin
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the lock rules.
      queue_request(REQ_READ, 0);       // free lock: reader granted at once
      queue_request(REQ_READ, 0);       // already approved reader: dropped
      queue_request(REQ_WRITE, 3);      // owner 3 waits for reader 0
      queue_request(REQ_READ, 5);       // queued behind the owner
      queue_request(REQ_READ, 3);       // queued in the owner's own slot
      queue_request(REQ_WRITE, 3);      // owner asks again: dropped
      queue_request(REQ_WRITE, 6);      // applying writer further round
      queue_request(REQ_RELEASE, 0);    // last reader out: writer 3 granted
      queue_request(REQ_RELEASE, 4);    // holds nothing: dropped
      queue_request(REQ_UNKNOWN, 7);    // unknown code: dropped
      queue_request(REQ_RELEASE, 3);    // walk: reader 5, stop at writer 6
      queue_request(REQ_RELEASE, 5);    // writer 6 granted
      queue_request(REQ_READ, 1);
      queue_request(REQ_READ, 7);
      queue_request(REQ_RELEASE, 6);    // walk wakes 7, 1, 3, lock freed
      queue_request(REQ_RELEASE, 7);
      queue_request(REQ_RELEASE, 1);
      queue_request(REQ_RELEASE, 3);
      queue_request(REQ_READ, 4);
      queue_request(REQ_WRITE, 4);      // own-slot reader does not block
      queue_request(REQ_RELEASE, 4);    // reader in the slot leaves first
      queue_request(REQ_READ, 4);       // queued in the owner's slot
      queue_request(REQ_READ, 0);
      queue_request(REQ_RELEASE, 4);    // lock freed, own-slot reader last
      queue_request(REQ_RELEASE, 0);
      queue_request(REQ_RELEASE, 4);
      wait_quiet();

      // Random traffic: noisy, then a calm burst after a full drain, then noisy.
      queue_random_requests(144);
      wait_quiet();
      calm = 1'b1;
      queue_random_requests(90);
      wait_quiet();
      calm = 1'b0;
      queue_random_requests(150);
      wait_quiet();

      // Let any stray grant after the walk show up.
      repeat (SLOTS + 8) @(negedge clock);
      if (mismatches == 0) begin
         $display("ring_order_reader_writer_lock_core_tb: PASS");
      end else begin
         $display("ring_order_reader_writer_lock_core_tb: FAIL");
      end
      $finish;
   end

endmodule
